@@ rtl/pcq_pkg.sv @@
// pcq_pkg: shared types and constants for the priority class queue
// holds payload structs, slot and control types, request codes
// no dependencies
package pcq_pkg;

  localparam int ID_W         = 32;
  localparam int CLS_W        = 2;
  localparam int HELD_W       = 5;
  localparam int CAPACITY_DEF = 16;

  // class codes, highest first
  localparam logic [CLS_W-1:0] PREMIUM = 2'd3;
  localparam logic [CLS_W-1:0] REGULAR = 2'd2;
  localparam logic [CLS_W-1:0] SAVINGS = 2'd1;
  localparam logic [CLS_W-1:0] NO_CLASS = 2'd0;

  typedef enum logic {
    REQ_ADD   = 1'b0,
    REQ_SERVE = 1'b1
  } pcq_req_t;

  typedef struct packed {
    pcq_req_t                 req_type;
    logic signed [ID_W-1:0]   entry_id;
    logic        [CLS_W-1:0]  entry_class;
  } pcq_in_t;

  typedef struct packed {
    logic                     served_valid;
    logic signed [ID_W-1:0]   served_id;
    logic        [CLS_W-1:0]  served_class;
    logic                     add_dropped;
    logic        [HELD_W-1:0] held_count;
  } pcq_out_t;

  // one queue slot
  typedef struct packed {
    logic signed [ID_W-1:0]  id;
    logic        [CLS_W-1:0] cls;
  } pcq_slot_t;

  // broadcast control to every cell
  typedef struct packed {
    logic add;
    logic srv;
  } pcq_ctl_t;

endpackage

@@ rtl/pcq_cell.sv @@
// pcq_cell: one slot of the insertion chain
// holds an entry, shifts toward the back on insert and toward the front on serve
// depends on pcq_pkg
module pcq_cell (
  input  logic               clk,
  input  pcq_pkg::pcq_ctl_t  ctl,
  input  logic               occ,
  input  pcq_pkg::pcq_slot_t new_slot,
  input  pcq_pkg::pcq_slot_t left_slot,
  input  logic               left_behind,
  input  pcq_pkg::pcq_slot_t right_slot,
  output pcq_pkg::pcq_slot_t slot,
  output logic               behind
);
  import pcq_pkg::*;

  pcq_slot_t slot_r;
  pcq_slot_t slot_nxt;

  // new entry goes behind this one when held class is equal or higher
  assign behind = occ && (slot_r.cls >= new_slot.cls);
  assign slot   = slot_r;

  always_comb begin
    slot_nxt = slot_r;
    if (ctl.srv) begin
      slot_nxt = right_slot;
    end else if (ctl.add && !behind) begin
      slot_nxt = left_behind ? new_slot : left_slot;
    end
  end

  always_ff @(posedge clk) begin
    slot_r <= slot_nxt;
  end

endmodule

@@ rtl/priority_class_queue_core.sv @@
// priority_class_queue_core: bounded three-level stable priority queue
// top level, builds a chain of pcq_cell slots plus a fill counter
// depends on pcq_pkg and pcq_cell
//
// usage
//   in channel: one word per request, req_type add or serve, with entry_id
//   and entry_class for an add (class 0 counts as the lowest class)
//   out channel: exactly one result word per request word, in order
//   result: registered, on out_valid the cycle after its request is taken
//   throughput: one request per cycle while in_ready is high; every slot cell
//   compares its class with the incoming class in parallel and shifts one
//   place, so the chain updates in the same cycle the word is taken
//   an add lands behind every held entry of equal or higher class, so each
//   class leaves first-in first-out; an add to a full queue is dropped and
//   flagged, a serve of an empty queue returns zeros
//   stall: the result register is the only buffer; in_ready stays high while
//   it is empty or being drained, so a stalled receiver holds off new words
//   reset: clears the fill count and the result valid; slot contents are not
//   cleared, since only slots below the fill count are ever read
module priority_class_queue_core #(
  parameter int CAPACITY = pcq_pkg::CAPACITY_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  pcq_pkg::pcq_in_t in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output pcq_pkg::pcq_out_t out_data
);
  import pcq_pkg::*;

  localparam int CNT_W = $clog2(CAPACITY + 1);

  // fill count and result register
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             out_valid_r, out_valid_nxt;
  pcq_out_t         out_data_r, out_data_nxt;

  logic      accept;
  logic      is_add, is_srv;
  logic      full, empty;
  pcq_ctl_t  ctl;
  pcq_slot_t new_slot;

  // chain wiring
  pcq_slot_t           slots  [CAPACITY];
  logic [CAPACITY-1:0] behind;
  logic [CAPACITY-1:0] occ;

  assign in_ready = !out_valid_r || out_ready;
  assign accept   = in_valid && in_ready;
  assign is_add   = (in_data.req_type == REQ_ADD);
  assign is_srv   = (in_data.req_type == REQ_SERVE);
  assign full     = (cnt_r == CNT_W'(CAPACITY));
  assign empty    = (cnt_r == '0);

  assign ctl.add = accept && is_add && !full;
  assign ctl.srv = accept && is_srv && !empty;

  // class 0 is taken as the lowest class
  assign new_slot.id  = in_data.entry_id;
  assign new_slot.cls = (in_data.entry_class == NO_CLASS) ? SAVINGS : in_data.entry_class;

  // slot chain, slot 0 is the front
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    pcq_slot_t left_s;
    pcq_slot_t right_s;
    logic      left_b;

    assign occ[i] = (CNT_W'(i) < cnt_r);

    if (i == 0) begin : g_front
      assign left_s = new_slot;
      assign left_b = 1'b1;
    end else begin : g_mid
      assign left_s = slots[i-1];
      assign left_b = behind[i-1];
    end

    if (i == CAPACITY - 1) begin : g_back
      assign right_s = slots[i];
    end else begin : g_inner
      assign right_s = slots[i+1];
    end

    pcq_cell u_cell (
      .clk        (clk),
      .ctl        (ctl),
      .occ        (occ[i]),
      .new_slot   (new_slot),
      .left_slot  (left_s),
      .left_behind(left_b),
      .right_slot (right_s),
      .slot       (slots[i]),
      .behind     (behind[i])
    );
  end

  // count and result word
  always_comb begin
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;

    if (ctl.add) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (ctl.srv) begin
      cnt_nxt = cnt_r - 1'b1;
    end

    if (accept) begin
      out_valid_nxt             = 1'b1;
      out_data_nxt.served_valid = ctl.srv;
      out_data_nxt.served_id    = ctl.srv ? slots[0].id  : '0;
      out_data_nxt.served_class = ctl.srv ? slots[0].cls : NO_CLASS;
      out_data_nxt.add_dropped  = is_add && full;
      out_data_nxt.held_count   = HELD_W'(cnt_nxt);
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // checks
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(CAPACITY))
    else $error("fill count above capacity");

  a_drop_on_full: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && is_add && full) |=> (out_valid && out_data.add_dropped && cnt_r == $past(cnt_r)))
    else $error("add to full queue not dropped");

  a_serve_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_data.served_valid && out_data.add_dropped))
    else $error("served and dropped in one result");

  a_serve_count: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.srv |=> (cnt_r == $past(cnt_r) - 1'b1 && out_data.served_valid))
    else $error("serve did not remove one entry");

endmodule

@@ tb/tb_priority_class_queue_core.sv @@
// tb_priority_class_queue_core: self-checking bench for the priority class queue
// drives add and serve words with random gaps and holds, predicts every result word
// depends on pcq_pkg and priority_class_queue_core
module tb_priority_class_queue_core;
  timeunit 1ns;
  timeprecision 1ps;

  import pcq_pkg::*;

  localparam int DEPTH       = CAPACITY_DEF;
  localparam int N_DIRECTED  = 25;
  localparam int N_RANDOM    = 950;
  localparam int N_WORDS     = N_DIRECTED + N_RANDOM;
  localparam int QUIET_TAIL  = 100;     // last words run with no idling
  localparam int HOLD_AFTER  = 400;     // long receiver hold starts after this many words
  localparam int HOLD_CYCLES = 80;
  localparam int DRAIN       = 10;      // cycles after the last result before the verdict
  localparam int CYCLE_LIMIT = 200000;
  localparam int MAX_REPORTS = 10;

  logic     clk = 1'b0;
  logic     rst_n = 1'b0;
  logic     in_valid = 1'b0;
  logic     in_ready;
  pcq_in_t  in_data = '0;
  logic     out_valid;
  logic     out_ready = 1'b0;
  pcq_out_t out_data;

  pcq_in_t   pending_q[$];     // words waiting to be offered
  pcq_out_t  result_q[$];      // predicted result words, oldest first
  pcq_slot_t held_q[$];        // predicted queue contents, front at index 0

  logic in_fire = 1'b0;        // word taken at the last rising edge
  logic hold_off = 1'b0;       // long receiver hold in progress
  int   taken_cnt = 0;
  int   err_cnt = 0;
  int   cycle_cnt = 0;
  int   in_gap = 0;
  int   out_gap = 0;

  priority_class_queue_core #(.CAPACITY(DEPTH)) DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // next state of the queue and the result word for one request
  function automatic pcq_out_t queue_step(pcq_in_t req);
    pcq_out_t  res;
    pcq_slot_t slot;
    int        pos;
    res = '0;
    if (req.req_type == REQ_ADD) begin
      // class zero is taken as the lowest class
      slot.id  = req.entry_id;
      slot.cls = (req.entry_class == NO_CLASS) ? SAVINGS : req.entry_class;
      if (held_q.size() >= DEPTH) begin
        res.add_dropped = 1'b1;
      end else begin
        // land behind every entry of equal or higher class
        pos = 0;
        while (pos < held_q.size() && held_q[pos].cls >= slot.cls) pos++;
        held_q.insert(pos, slot);
      end
    end else if (held_q.size() > 0) begin
      res.served_valid = 1'b1;
      res.served_id    = held_q[0].id;
      res.served_class = held_q[0].cls;
      void'(held_q.pop_front());
    end
    res.held_count = HELD_W'(held_q.size());
    return res;
  endfunction

  function automatic pcq_in_t make_req(pcq_req_t kind, logic signed [ID_W-1:0] id,
                                       logic [CLS_W-1:0] cls);
    pcq_in_t req;
    req.req_type    = kind;
    req.entry_id    = id;
    req.entry_class = cls;
    return req;
  endfunction

  // random request; ids lean toward the extremes, class covers all four codes
  function automatic pcq_in_t rand_req(int add_pct);
    logic signed [ID_W-1:0] id;
    case ($urandom_range(0, 7))
      0: id = 32'sh8000_0000;
      1: id = 32'sh7FFF_FFFF;
      2: id = '0;
      3: id = -32'sd1;
      default: id = $urandom;
    endcase
    return make_req(($urandom_range(0, 99) < add_pct) ? REQ_ADD : REQ_SERVE, id,
                    CLS_W'($urandom_range(0, 3)));
  endfunction

  // stimulus: directed words, then random segments that swing the fill level
  initial begin
    pending_q.push_back(make_req(REQ_SERVE, 32'sh1234_5678, PREMIUM));   // serve of empty queue
    pending_q.push_back(make_req(REQ_ADD, 32'sh7FFF_FFFF, PREMIUM));
    pending_q.push_back(make_req(REQ_ADD, 32'sh8000_0000, SAVINGS));
    pending_q.push_back(make_req(REQ_ADD, '0, NO_CLASS));                // class zero -> lowest
    pending_q.push_back(make_req(REQ_ADD, -32'sd1, REGULAR));
    for (int i = 0; i < 12; i++)
      pending_q.push_back(make_req(REQ_ADD, 32'sh0101_0000 * (i + 1), CLS_W'(i % 4)));
    pending_q.push_back(make_req(REQ_ADD, 32'shDEAD_BEEF, PREMIUM));     // full queue, dropped
    for (int i = 0; i < 7; i++)
      pending_q.push_back(make_req(REQ_SERVE, -32'sd1, PREMIUM));

    for (int seg = 0; seg < N_RANDOM / 50; seg++) begin
      // alternate filling and draining phases so both full and empty recur
      int add_pct;
      add_pct = (seg % 2 == 0) ? $urandom_range(65, 95) : $urandom_range(5, 40);
      for (int i = 0; i < 50; i++) pending_q.push_back(rand_req(add_pct));
    end

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // all words offered, last one taken, every result seen
    do @(negedge clk);
    while (pending_q.size() != 0 || in_valid || result_q.size() != 0);
    repeat (DRAIN) @(negedge clk);
    if (err_cnt == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

  // sender: inputs move on the falling edge, a word holds until taken
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!(in_valid && !in_fire)) begin
      if (in_gap > 0) begin
        in_gap = in_gap - 1;
        in_valid <= 1'b0;
      end else if (pending_q.size() == 0) begin
        in_valid <= 1'b0;
      end else if (pending_q.size() > QUIET_TAIL && $urandom_range(0, 9) == 0) begin
        // random idle burst, starting with this one
        in_gap = $urandom_range(1, 9) - 1;
        in_valid <= 1'b0;
      end else begin
        in_data  <= pending_q.pop_front();
        in_valid <= 1'b1;
      end
    end
  end

  // receiver: random stall bursts, the long hold, none in the tail
  always @(negedge clk) begin
    if (hold_off) begin
      out_ready <= 1'b0;
    end else if (out_gap > 0) begin
      out_gap = out_gap - 1;
      out_ready <= 1'b0;
    end else if (taken_cnt < N_WORDS - QUIET_TAIL && $urandom_range(0, 7) == 0) begin
      out_gap = $urandom_range(1, 9) - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // long receiver hold while the sender keeps offering, so in_ready must drop
  initial begin
    do @(posedge clk);
    while (taken_cnt < HOLD_AFTER);
    hold_off <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_off <= 1'b0;
  end

  // monitor: check result words first, then predict for the word taken
  always @(posedge clk) begin
    pcq_out_t want;
    if (!rst_n) begin
      in_fire <= 1'b0;
    end else begin
      in_fire <= in_valid && in_ready;
      if (out_valid && out_ready) begin
        if (result_q.size() == 0) begin
          err_cnt++;
          if (err_cnt <= MAX_REPORTS)
            $display("unexpected result word %p", out_data);
        end else begin
          want = result_q.pop_front();
          if (out_data.served_valid !== want.served_valid ||
              out_data.served_id    !== want.served_id    ||
              out_data.served_class !== want.served_class ||
              out_data.add_dropped  !== want.add_dropped  ||
              out_data.held_count   !== want.held_count) begin
            err_cnt++;
            if (err_cnt <= MAX_REPORTS)
              $display("result mismatch: expected %p, got %p", want, out_data);
          end
        end
      end
      if (in_valid && in_ready) begin
        result_q.push_back(queue_step(in_data));
        taken_cnt <= taken_cnt + 1;
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

endmodule
